>>> rtl/core/rwcg_pkg.sv
// ----------------------------------------------------------------------------
// rwcg_pkg
// Shared types and constants of the rolling wave color generator.
// ----------------------------------------------------------------------------
package rwcg_pkg;

  localparam int PATTERN_DEPTH = 64;
  localparam int PALETTE_DEPTH = 64;
  localparam int PAT_AW        = $clog2(PATTERN_DEPTH);
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

  localparam int COLOR_W = 24;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 14;
  localparam int DVD_W   = 16;
  localparam int DVS_W   = 14;

  // request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_PAT  = 2'd1;
  localparam logic [1:0] REQ_PAL  = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_GRAD    = 3'd0;
  localparam logic [2:0] CFG_SPACING = 3'd1;
  localparam logic [2:0] CFG_TRAIL   = 3'd2;
  localparam logic [2:0] CFG_DIM     = 3'd3;
  localparam logic [2:0] CFG_BG      = 3'd4;
  localparam logic [2:0] CFG_PLEN    = 3'd5;

  // trail modes
  localparam logic [1:0] TRAIL_END  = 2'd0;
  localparam logic [1:0] TRAIL_BOTH = 2'd1;
  localparam logic [1:0] TRAIL_LEAD = 2'd2;

  typedef struct packed {
    logic               pat_we;
    logic               pal_we;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] data;
  } tbl_wr_t;

endpackage

>>> rtl/core/rolling_wave_color_generator_unit.sv
// ----------------------------------------------------------------------------
// rolling_wave_color_generator_unit
// Produces the color of the pixel entering the head of a strip, per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: a tick, a pattern
//   table write or a palette table write. Writes return nothing; unknown
//   request codes are dropped. A tick returns one result on the output
//   channel (out_valid/out_ready): red, green, blue, is_background.
//   Configuration registers are written over cfg_valid/cfg_ready, which is
//   ready whenever reset is low; write them only while no tick is in flight.
// Sequencing:
//   One request at a time. A tick runs two serial divisions (counter modulo
//   cycle length, then quotient and remainder by the wave length) on the
//   shared divider, a chained table read (S_PAT, S_PAL, S_LOAD) at wave step 0,
//   and a third division for the trail dim ratio on trail pixels. Writes are
//   accepted back to back.
// Reset:
//   Registers return to their defaults, counter and wave color clear. Table
//   contents are undefined until written. Both input sides hold ready low.
// Stall:
//   The result sits in an output register; the next request is accepted while
//   it waits, and a following tick holds in its final step until it is taken.
// ----------------------------------------------------------------------------
module rolling_wave_color_generator_unit (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [5:0]  entry_index,
  input  logic [23:0] entry_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        is_background,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_MOD_W, S_DIV, S_DIV_W, S_PAT, S_PAL, S_LOAD,
    S_CALC, S_RATIO_W, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [6:0]  grad_length;
  logic [7:0]  spacing;
  logic [1:0]  trail_mode;
  logic [7:0]  dim_power;
  logic [23:0] bg_color;
  logic [6:0]  pattern_length;

  // tick state
  logic [rwcg_pkg::CNT_W-1:0]   cycle_count;
  logic [rwcg_pkg::COLOR_W-1:0] wave_color;
  logic [rwcg_pkg::CNT_W-1:0]   cyc;
  logic [7:0]                   step;
  logic [rwcg_pkg::PAT_AW-1:0]  pat_idx;
  logic                         bg_flag;

  // table and divider hookup
  rwcg_pkg::tbl_wr_t             tbl_wr;
  logic [rwcg_pkg::IDX_W-1:0]    pat_q;
  logic [rwcg_pkg::COLOR_W-1:0]  pal_q;
  logic                          div_start;
  logic [rwcg_pkg::DVD_W-1:0]    div_dividend;
  logic [rwcg_pkg::DVS_W-1:0]    div_divisor;
  logic                          div_done;
  logic [rwcg_pkg::DVD_W-1:0]    div_quo;
  logic [rwcg_pkg::DVS_W-1:0]    div_rem;

  // clamped geometry
  logic [6:0]  grad_c;
  logic [7:0]  spacing_c;
  logic [6:0]  plen_c;
  logic [8:0]  wave_len;
  logic [15:0] total_full;
  logic [rwcg_pkg::CNT_W-1:0] total;
  logic [rwcg_pkg::CNT_W-1:0] cyc_inc;

  // trail decode
  logic [6:0]  half;
  logic [6:0]  first;
  logic [6:0]  mid;
  logic        adjust;
  logic        lt_first;
  logic        is_bg;
  logic        is_head;
  logic [7:0]  trail_dist;
  logic [15:0] dim_prod;
  logic [7:0]  half_inc;

  // scaling
  logic [7:0]  ratio;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;

  logic in_fire;
  logic out_free;

  assign in_ready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign grad_c    = (grad_length == 7'd0) ? 7'd1 : grad_length;
  assign spacing_c = (spacing > 8'd128) ? 8'd128 : spacing;
  assign plen_c    = (pattern_length == 7'd0) ? 7'd1 :
                     (pattern_length > 7'd64) ? 7'd64 : pattern_length;
  assign wave_len  = {2'b00, grad_c} + {1'b0, spacing_c};
  assign total_full = {9'd0, plen_c} * {7'd0, wave_len};
  assign total     = total_full[rwcg_pkg::CNT_W-1:0];
  assign cyc_inc   = cyc + rwcg_pkg::CNT_W'(1);

  always_comb begin
    case (trail_mode)
      rwcg_pkg::TRAIL_END: begin
        half = grad_c; first = 7'd0; mid = 7'd0; adjust = 1'b0;
      end
      rwcg_pkg::TRAIL_LEAD: begin
        half = grad_c; first = grad_c; mid = grad_c - 7'd1; adjust = 1'b0;
      end
      default: begin
        // both trails; the unused code behaves the same
        half = grad_c >> 1; first = grad_c >> 1; mid = grad_c >> 1;
        adjust = grad_c[0];
      end
    endcase
  end

  assign lt_first = step < {1'b0, first};
  assign is_bg    = step >= {1'b0, grad_c};
  assign is_head  = step == {1'b0, mid};
  assign trail_dist = lt_first ? ({1'b0, half} - step)
                               : ({1'b0, half} - {1'b0, grad_c} + step + {7'd0, adjust});
  assign dim_prod = trail_dist * dim_power;
  assign half_inc = {1'b0, half} + 8'd1;

  assign ratio  = dim_power - div_quo[7:0];
  assign prod_r = wave_color[23:16] * ratio;
  assign prod_g = wave_color[15:8] * ratio;
  assign prod_b = wave_color[7:0] * ratio;

  // divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      S_MOD: begin
        div_start    = 1'b1;
        div_dividend = {2'b00, cycle_count};
        div_divisor  = total;
      end
      S_DIV: begin
        div_start    = 1'b1;
        div_dividend = {2'b00, cyc};
        div_divisor  = {5'd0, wave_len};
      end
      S_CALC: begin
        div_start    = !(is_bg || is_head);
        div_dividend = dim_prod;
        div_divisor  = {6'd0, half_inc};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // table writes go straight from the accepted request
  always_comb begin
    tbl_wr.pat_we = in_fire && (req_type == rwcg_pkg::REQ_PAT);
    tbl_wr.pal_we = in_fire && (req_type == rwcg_pkg::REQ_PAL);
    tbl_wr.idx    = entry_index;
    tbl_wr.data   = entry_value;
  end

  rwcg_tables u_tables (
    .clk      (clk),
    .wr       (tbl_wr),
    .pat_addr (pat_idx),
    .pat_q    (pat_q),
    .pal_q    (pal_q)
  );

  rwcg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grad_length    <= 7'd8;
      spacing        <= 8'd0;
      trail_mode     <= rwcg_pkg::TRAIL_END;
      dim_power      <= 8'd255;
      bg_color       <= 24'd0;
      pattern_length <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rwcg_pkg::CFG_GRAD:    grad_length    <= cfg_data[6:0];
        rwcg_pkg::CFG_SPACING: spacing        <= cfg_data[7:0];
        rwcg_pkg::CFG_TRAIL:   trail_mode     <= cfg_data[1:0];
        rwcg_pkg::CFG_DIM:     dim_power      <= cfg_data[7:0];
        rwcg_pkg::CFG_BG:      bg_color       <= cfg_data;
        rwcg_pkg::CFG_PLEN:    pattern_length <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // tick sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      cycle_count <= '0;
      wave_color  <= '0;
    end else begin
      // drop the taken result, unless S_OUT reloads the register this edge
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && (req_type == rwcg_pkg::REQ_TICK)) begin
            state <= S_MOD;
          end
        end
        S_MOD:   state <= S_MOD_W;
        S_MOD_W: begin
          if (div_done) begin
            cyc   <= div_rem;
            state <= S_DIV;
          end
        end
        S_DIV:   state <= S_DIV_W;
        S_DIV_W: begin
          if (div_done) begin
            step    <= div_rem[7:0];
            pat_idx <= div_quo[rwcg_pkg::PAT_AW-1:0];
            // new wave: fetch its color first
            state   <= (div_rem == '0) ? S_PAT : S_CALC;
          end
        end
        S_PAT:  state <= S_PAL;
        S_PAL:  state <= S_LOAD;
        S_LOAD: begin
          wave_color <= pal_q;
          state      <= S_CALC;
        end
        S_CALC: begin
          bg_flag <= is_bg;
          state   <= (is_bg || is_head) ? S_OUT : S_RATIO_W;
        end
        S_RATIO_W: begin
          if (div_done) begin
            // dimming compounds along the wave
            wave_color <= {prod_r[15:8], prod_g[15:8], prod_b[15:8]};
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            is_background <= bg_flag;
            red           <= bg_flag ? bg_color[23:16] : wave_color[23:16];
            green         <= bg_flag ? bg_color[15:8]  : wave_color[15:8];
            blue          <= bg_flag ? bg_color[7:0]   : wave_color[7:0];
            cycle_count   <= (cyc_inc == total) ? '0 : cyc_inc;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/rwcg_div.sv
// ----------------------------------------------------------------------------
// rwcg_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwcg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rwcg_pkg::DVD_W-1:0]  dividend,
  input  logic [rwcg_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [rwcg_pkg::DVD_W-1:0]  quotient,
  output logic [rwcg_pkg::DVS_W-1:0]  remainder
);

  localparam int CW = $clog2(rwcg_pkg::DVD_W + 1);

  logic [rwcg_pkg::DVD_W-1:0] quo;
  logic [rwcg_pkg::DVS_W-1:0] rem;
  logic [rwcg_pkg::DVS_W-1:0] dvs;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic [rwcg_pkg::DVS_W:0]   trial;
  logic [rwcg_pkg::DVS_W:0]   diff;
  logic                       fits;

  assign trial = {rem, quo[rwcg_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse done with the last quotient bit
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(rwcg_pkg::DVD_W);
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        // shift in one dividend bit, subtract when it fits
        rem <= fits ? diff[rwcg_pkg::DVS_W-1:0] : trial[rwcg_pkg::DVS_W-1:0];
        quo <= {quo[rwcg_pkg::DVD_W-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

>>> rtl/core/rwcg_tables.sv
// ----------------------------------------------------------------------------
// rwcg_tables
// Pattern and palette memories; the palette is addressed by the pattern read.
// ----------------------------------------------------------------------------
module rwcg_tables (
  input  logic                          clk,
  input  rwcg_pkg::tbl_wr_t             wr,
  input  logic [rwcg_pkg::PAT_AW-1:0]   pat_addr,
  output logic [rwcg_pkg::IDX_W-1:0]    pat_q,
  output logic [rwcg_pkg::COLOR_W-1:0]  pal_q
);

  logic [rwcg_pkg::IDX_W-1:0]   pat_mem [rwcg_pkg::PATTERN_DEPTH];
  logic [rwcg_pkg::COLOR_W-1:0] pal_mem [rwcg_pkg::PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.pat_we) begin
      pat_mem[wr.idx[rwcg_pkg::PAT_AW-1:0]] <= wr.data[rwcg_pkg::IDX_W-1:0];
    end
    pat_q <= pat_mem[pat_addr];
  end

  // chained read: palette address is last cycle's pattern data
  always_ff @(posedge clk) begin
    if (wr.pal_we) begin
      pal_mem[wr.idx[rwcg_pkg::PAL_AW-1:0]] <= wr.data;
    end
    pal_q <= pal_mem[pat_q[rwcg_pkg::PAL_AW-1:0]];
  end

endmodule
